// ===== rtl/b85_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b85_pkg: shared types, codes and tables of the base-85 group encoder
// Register indexes, alphabet codes, the job word passed from the front to the
// back, the converter state type and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package b85_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_ALPHABET_SELECT       = 3'd0;
   localparam logic [2:0] REG_ZERO_SHORTCUT_ENABLE  = 3'd1;
   localparam logic [2:0] REG_ZERO_SHORTCUT_CHAR    = 3'd2;
   localparam logic [2:0] REG_SPACE_SHORTCUT_ENABLE = 3'd3;
   localparam logic [2:0] REG_SPACE_SHORTCUT_CHAR   = 3'd4;
   localparam logic [2:0] REG_PAD_ENABLE            = 3'd5;

   // Alphabet codes
   localparam logic [1:0] ALPHA_ORIGINAL = 2'd0;
   localparam logic [1:0] ALPHA_Z85      = 2'd1;
   localparam logic [1:0] ALPHA_RFC1924  = 2'd2;

   // Default depth of the job queue between front and back
   localparam int B85_QUEUE_DEPTH = 2;

   // floor(2^38 / 85): estimate of v / 85 is off by at most one below
   localparam logic [31:0] RECIP_85   = 32'd3233857728;
   localparam int          RECIP_SHIFT = 38;

   // Digit alphabets, first character in the top byte
   localparam logic [85*8-1:0] Z85_SET =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
   localparam logic [85*8-1:0] RFC_SET =
      {"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_",
       8'h60, "{|}~"};

   typedef struct packed {
      logic [1:0] alphabet_select;
      logic       zero_enable;
      logic [7:0] zero_char;
      logic       space_enable;
      logic [7:0] space_char;
      logic       pad_enable;
   } b85_cfg_type;

   // One unit of work for the back: a single character or a digit group
   typedef struct packed {
      logic        single;
      logic [7:0]  single_char;
      logic        pad_error;
      logic [2:0]  char_count;
      logic        last;
      logic [31:0] value;
   } b85_job_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_MUL,
      CONV_FIX,
      CONV_DONE
   } b85_conv_state_type;

   // Map a digit 0..84 to its character; larger digits clamp to 84
   function automatic logic [7:0] digit_char(input logic [6:0] digit,
                                             input logic [1:0] sel);
      logic [6:0] d;
      logic [9:0] pos;
      d   = (digit > 7'd84) ? 7'd84 : digit;
      pos = {3'b000, 7'd84 - d} << 3;
      case (sel)
         ALPHA_Z85: begin
            digit_char = Z85_SET[pos +: 8];
         end
         ALPHA_RFC1924: begin
            digit_char = RFC_SET[pos +: 8];
         end
         ALPHA_ORIGINAL: begin
            digit_char = 8'h21 + {1'b0, d};
         end
         default: begin
            digit_char = 8'h21 + {1'b0, d};
         end
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== rtl/b85_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b85_front: byte gathering and group classification
// Collects bytes into big-endian groups of four and, at a full group or at
// the end of the stream, pushes one job describing what the back must emit.
// ----------------------------------------------------------------------------
module b85_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_stream_last,
   input  b85_pkg::b85_cfg_type cfg,
   input  logic                 queue_full,
   output logic                 job_push,
   output b85_pkg::b85_job_type job
);
   import b85_pkg::*;

   logic [23:0] group_ff;
   logic [23:0] group_in;
   logic [1:0]  bytes_ff;
   logic [1:0]  bytes_in;
   logic        accept;
   logic [2:0]  count;
   logic [31:0] full_value;
   logic [31:0] padded_value;
   logic        group_done;

   // Take a word whenever the queue has room
   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign count      = {1'b0, bytes_ff} + 3'd1;
   assign full_value = {group_ff, req_data_byte};
   assign group_done = (count == 3'd4) || req_stream_last;
   assign job_push   = accept && group_done;

   // Zero-pad a short final group to four bytes
   always_comb begin
      case (count)
         3'd1: begin
            padded_value = {req_data_byte, 24'h000000};
         end
         3'd2: begin
            padded_value = {group_ff[7:0], req_data_byte, 16'h0000};
         end
         3'd3: begin
            padded_value = {group_ff[15:0], req_data_byte, 8'h00};
         end
         default: begin
            padded_value = full_value;
         end
      endcase
   end

   // Classify the finished group
   always_comb begin
      job.single      = 1'b0;
      job.single_char = 8'h00;
      job.pad_error   = 1'b0;
      job.char_count  = 3'd5;
      job.last        = req_stream_last;
      job.value       = padded_value;
      if (count == 3'd4) begin
         if (cfg.zero_enable && (full_value == 32'h00000000)) begin
            job.single      = 1'b1;
            job.single_char = cfg.zero_char;
            job.char_count  = 3'd1;
         end else if (cfg.space_enable && (full_value == 32'h20202020)) begin
            job.single      = 1'b1;
            job.single_char = cfg.space_char;
            job.char_count  = 3'd1;
         end
      end else if (!cfg.pad_enable) begin
         job.single     = 1'b1;
         job.pad_error  = 1'b1;
         job.char_count = 3'd1;
         job.last       = 1'b1;
      end else begin
         job.char_count = count + 3'd1;
      end
   end

   // Advance the gathering state
   always_comb begin
      group_in = group_ff;
      bytes_in = bytes_ff;
      if (accept) begin
         if (group_done) begin
            bytes_in = 2'd0;
         end else begin
            bytes_in = count[1:0];
            group_in = full_value[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= 2'd0;
      end else begin
         bytes_ff <= bytes_in;
      end
      group_ff <= group_in;
   end

endmodule
`default_nettype wire

// ===== rtl/b85_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b85_queue: short job queue between front and back
// A small register-based first-in first-out buffer of jobs.
// ----------------------------------------------------------------------------
module b85_queue #(
   parameter int DEPTH = b85_pkg::B85_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b85_pkg::b85_job_type push_job,
   input  logic                 pop,
   output b85_pkg::b85_job_type pop_job,
   output logic                 full,
   output logic                 empty
);
   import b85_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b85_job_type      entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/b85_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b85_back: digit conversion and character emission
// A converter splits each group into five base-85 digits by repeated division
// by 85, while an emitter sends the previous job out one character a cycle,
// when the output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module b85_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b85_pkg::b85_cfg_type cfg,
   input  logic                 queue_empty,
   input  b85_pkg::b85_job_type queue_job,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_code_char,
   output logic                 rsp_run_last,
   output logic                 rsp_stream_done,
   output logic                 rsp_pad_error
);
   import b85_pkg::*;

   // Converter state
   b85_conv_state_type state_ff;
   b85_conv_state_type state_in;
   b85_job_type        cv_job_ff;
   logic [31:0]        cv_value_ff;
   logic [63:0]        prod_ff;
   logic [1:0]         iter_ff;
   logic [6:0]         cv_digit_ff [0:4];

   logic               hand;
   logic               step_mul;
   logic               step_fix;

   logic [25:0]        q_est;
   logic [31:0]        rem_full;
   logic [7:0]         rem_est;
   logic               fix_hit;
   logic [7:0]         fix_rem;
   logic [25:0]        fix_quot;
   logic [2:0]         digit_pos;

   // Emitter state
   logic               em_valid_ff;
   b85_job_type        em_job_ff;
   logic [6:0]         em_digit_ff [0:4];
   logic [2:0]         em_idx_ff;
   logic               out_free;
   logic               em_fire;
   logic               em_final;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_code_char_ff;
   logic               rsp_run_last_ff;
   logic               rsp_stream_done_ff;
   logic               rsp_pad_error_ff;

   // Next state of the converter
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (!queue_empty) begin
               state_in = queue_job.single ? CONV_DONE : CONV_MUL;
            end
         end
         CONV_MUL: begin
            state_in = CONV_FIX;
         end
         CONV_FIX: begin
            state_in = (iter_ff == 2'd3) ? CONV_DONE : CONV_MUL;
         end
         CONV_DONE: begin
            if (!em_valid_ff) begin
               if (!queue_empty) begin
                  state_in = queue_job.single ? CONV_DONE : CONV_MUL;
               end else begin
                  state_in = CONV_IDLE;
               end
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   // Converter control outputs
   always_comb begin
      hand      = 1'b0;
      queue_pop = 1'b0;
      step_mul  = 1'b0;
      step_fix  = 1'b0;
      case (state_ff)
         CONV_IDLE: begin
            queue_pop = !queue_empty;
         end
         CONV_MUL: begin
            step_mul = 1'b1;
         end
         CONV_FIX: begin
            step_fix = 1'b1;
         end
         CONV_DONE: begin
            hand      = !em_valid_ff;
            queue_pop = !em_valid_ff && !queue_empty;
         end
         default: begin
            hand = 1'b0;
         end
      endcase
   end

   // Correct the reciprocal estimate of the quotient by at most one
   assign q_est     = prod_ff[63:RECIP_SHIFT];
   assign rem_full  = cv_value_ff - ({6'd0, q_est} * 32'd85);
   assign rem_est   = rem_full[7:0];
   assign fix_hit   = (rem_est >= 8'd85);
   assign fix_rem   = fix_hit ? (rem_est - 8'd85) : rem_est;
   assign fix_quot  = q_est + {25'd0, fix_hit};
   assign digit_pos = 3'd4 - {1'b0, iter_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Load a job, multiply, then fix up and store one digit
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cv_job_ff   <= queue_job;
         cv_value_ff <= queue_job.value;
         iter_ff     <= 2'd0;
      end else if (step_fix) begin
         cv_value_ff            <= {6'd0, fix_quot};
         iter_ff                <= iter_ff + 2'd1;
         cv_digit_ff[digit_pos] <= fix_rem[6:0];
         if (iter_ff == 2'd3) begin
            cv_digit_ff[0] <= fix_quot[6:0];
         end
      end
      if (step_mul) begin
         prod_ff <= cv_value_ff * RECIP_85;
      end
   end

   // Emitter: one character per free output slot
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign em_fire  = em_valid_ff && out_free;
   assign em_final = (em_idx_ff == (em_job_ff.char_count - 3'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
      end else if (hand) begin
         em_valid_ff <= 1'b1;
      end else if (em_fire && em_final) begin
         em_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hand) begin
         em_job_ff   <= cv_job_ff;
         em_digit_ff <= cv_digit_ff;
         em_idx_ff   <= 3'd0;
      end else if (em_fire) begin
         em_idx_ff <= em_idx_ff + 3'd1;
      end
   end

   // Output register: load on a fire, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (em_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (em_fire) begin
         rsp_code_char_ff   <= em_job_ff.single ? em_job_ff.single_char :
                               digit_char(em_digit_ff[em_idx_ff], cfg.alphabet_select);
         rsp_run_last_ff    <= em_final;
         rsp_stream_done_ff <= em_final && em_job_ff.last;
         rsp_pad_error_ff   <= em_job_ff.pad_error;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_char   = rsp_code_char_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_stream_done = rsp_stream_done_ff;
   assign rsp_pad_error   = rsp_pad_error_ff;

`ifndef NO_ASSERTIONS
   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV_FIX) |-> (fix_rem < 8'd85))
      else $error("base-85 remainder out of range");

   a_error_closes_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pad_error) |-> (rsp_run_last && rsp_stream_done))
      else $error("pad error word does not close the stream");

   a_final_frees_emitter: assert property (@(posedge clock) disable iff (reset)
      (em_fire && em_final) |=> !em_valid_ff)
      else $error("emitter still busy after its final character");
`endif

endmodule
`default_nettype wire

// ===== rtl/base85_group_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// base85_group_encoder_core: base-85 encoder of a byte stream
// Gathers bytes into four-byte groups and emits base-85 characters.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte a word, req_stream_last marking the final byte.
//   rsp_* carries one character a word, with run_last on the last character
//   of each group, stream_done on the last of the stream and pad_error on
//   the single word given for a short final group when padding is off.
//   csr_* writes the six configuration registers; write only while idle.
// Timing:
//   A full group passes the converter as four divisions by 85, each a
//   reciprocal multiply and a correction step, plus hand-over; the emitter
//   sends one character a cycle meanwhile when the output is not stalled.
//   Bytes of an unfinished group are taken every cycle while the job queue
//   has room.
// Reset and stall:
//   Reset empties the queue and the group and restores register defaults.
//   A stalled result holds; the queue fills and then req_stall rises.
// ----------------------------------------------------------------------------
module base85_group_encoder_core #(
   parameter int QUEUE_DEPTH = b85_pkg::B85_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_code_char,
   output logic       rsp_run_last,
   output logic       rsp_stream_done,
   output logic       rsp_pad_error,
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import b85_pkg::*;

   logic [1:0]  alphabet_ff;
   logic        zero_en_ff;
   logic [7:0]  zero_char_ff;
   logic        space_en_ff;
   logic [7:0]  space_char_ff;
   logic        pad_en_ff;

   b85_cfg_type cfg;
   b85_job_type push_job;
   b85_job_type pop_job;
   logic        push;
   logic        pop;
   logic        queue_full;
   logic        queue_empty;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff   <= ALPHA_ORIGINAL;
         zero_en_ff    <= 1'b1;
         zero_char_ff  <= 8'd122;
         space_en_ff   <= 1'b0;
         space_char_ff <= 8'd121;
         pad_en_ff     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_ALPHABET_SELECT: begin
               alphabet_ff <= csr_wdata[1:0];
            end
            REG_ZERO_SHORTCUT_ENABLE: begin
               zero_en_ff <= csr_wdata[0];
            end
            REG_ZERO_SHORTCUT_CHAR: begin
               zero_char_ff <= csr_wdata;
            end
            REG_SPACE_SHORTCUT_ENABLE: begin
               space_en_ff <= csr_wdata[0];
            end
            REG_SPACE_SHORTCUT_CHAR: begin
               space_char_ff <= csr_wdata;
            end
            REG_PAD_ENABLE: begin
               pad_en_ff <= csr_wdata[0];
            end
            default: begin
               pad_en_ff <= pad_en_ff;
            end
         endcase
      end
   end

   assign cfg.alphabet_select = alphabet_ff;
   assign cfg.zero_enable     = zero_en_ff;
   assign cfg.zero_char       = zero_char_ff;
   assign cfg.space_enable    = space_en_ff;
   assign cfg.space_char      = space_char_ff;
   assign cfg.pad_enable      = pad_en_ff;

   b85_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_stream_last (req_stream_last),
      .cfg             (cfg),
      .queue_full      (queue_full),
      .job_push        (push),
      .job             (push_job)
   );

   b85_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   b85_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .queue_empty     (queue_empty),
      .queue_job       (pop_job),
      .queue_pop       (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_char   (rsp_code_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .rsp_pad_error   (rsp_pad_error)
   );

endmodule
`default_nettype wire
